/* design/mke_pkg.sv */
// Shared types, constants and the Morse pattern table of the keying encoder.
package mke_pkg;

    localparam int CHAR_W = 8;
    localparam int UNIT_W = 16;
    localparam int DUR_W  = 19;
    localparam int PAT_W  = 6;
    localparam int LEN_W  = 3;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd60;
    localparam logic [CHAR_W-1:0] CASE_FOLD  = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7A;

    // Register index, taken from the word address of the APB port
    typedef enum logic [0:0] {
        REG_UNIT_LENGTH = 1'b0
    } t_reg_idx;

    // Raw pattern: element count and elements, first element in bit (len-1), 1 = dash
    typedef struct packed {
        logic             ok;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] bits;
    } t_pat;

    // Queued work for the sequencer: elements left-aligned, first element in the MSB
    typedef struct packed {
        logic             space;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] bits;
    } t_desc;

    function automatic t_pat mke_pattern(input logic [CHAR_W-1:0] c);
        t_pat p;
        p = '{ok: 1'b1, len: 3'd0, bits: 6'h00};
        unique case (c)
            8'h41: begin p.len = 3'd2; p.bits = 6'h01; end // A
            8'h42: begin p.len = 3'd4; p.bits = 6'h08; end
            8'h43: begin p.len = 3'd4; p.bits = 6'h0A; end
            8'h44: begin p.len = 3'd3; p.bits = 6'h04; end
            8'h45: begin p.len = 3'd1; p.bits = 6'h00; end
            8'h46: begin p.len = 3'd4; p.bits = 6'h02; end
            8'h47: begin p.len = 3'd3; p.bits = 6'h06; end
            8'h48: begin p.len = 3'd4; p.bits = 6'h00; end
            8'h49: begin p.len = 3'd2; p.bits = 6'h00; end
            8'h4A: begin p.len = 3'd4; p.bits = 6'h07; end
            8'h4B: begin p.len = 3'd3; p.bits = 6'h05; end
            8'h4C: begin p.len = 3'd4; p.bits = 6'h04; end
            8'h4D: begin p.len = 3'd2; p.bits = 6'h03; end
            8'h4E: begin p.len = 3'd2; p.bits = 6'h02; end
            8'h4F: begin p.len = 3'd3; p.bits = 6'h07; end
            8'h50: begin p.len = 3'd4; p.bits = 6'h06; end
            8'h51: begin p.len = 3'd4; p.bits = 6'h0D; end
            8'h52: begin p.len = 3'd3; p.bits = 6'h02; end
            8'h53: begin p.len = 3'd3; p.bits = 6'h00; end
            8'h54: begin p.len = 3'd1; p.bits = 6'h01; end
            8'h55: begin p.len = 3'd3; p.bits = 6'h01; end
            8'h56: begin p.len = 3'd4; p.bits = 6'h01; end
            8'h57: begin p.len = 3'd3; p.bits = 6'h03; end
            8'h58: begin p.len = 3'd4; p.bits = 6'h09; end
            8'h59: begin p.len = 3'd4; p.bits = 6'h0B; end
            8'h5A: begin p.len = 3'd4; p.bits = 6'h0C; end // Z
            8'h30: begin p.len = 3'd5; p.bits = 6'h1F; end // 0
            8'h31: begin p.len = 3'd5; p.bits = 6'h0F; end
            8'h32: begin p.len = 3'd5; p.bits = 6'h07; end
            8'h33: begin p.len = 3'd5; p.bits = 6'h03; end
            8'h34: begin p.len = 3'd5; p.bits = 6'h01; end
            8'h35: begin p.len = 3'd5; p.bits = 6'h00; end
            8'h36: begin p.len = 3'd5; p.bits = 6'h10; end
            8'h37: begin p.len = 3'd5; p.bits = 6'h18; end
            8'h38: begin p.len = 3'd5; p.bits = 6'h1C; end
            8'h39: begin p.len = 3'd5; p.bits = 6'h1E; end // 9
            8'h2F: begin p.len = 3'd5; p.bits = 6'h12; end // slash
            8'h3F: begin p.len = 3'd6; p.bits = 6'h0C; end // question mark
            8'h2E: begin p.len = 3'd6; p.bits = 6'h15; end // full stop
            8'h2C: begin p.len = 3'd6; p.bits = 6'h33; end // comma
            default: begin p.ok = 1'b0; end
        endcase
        return p;
    endfunction

endpackage

/* design/mke_if.sv */
// Handshake channels of the keying encoder: character input and key segment output.
interface mke_char_if;
    logic                       valid;
    logic                       ready;
    logic [mke_pkg::CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface mke_seg_if;
    logic                      valid;
    logic                      ready;
    logic                      key_down;
    logic [mke_pkg::DUR_W-1:0] duration_ms;
    logic                      last_of_run;

    modport source (output valid, output key_down, output duration_ms,
                    output last_of_run, input ready);
    modport sink   (input valid, input key_down, input duration_ms,
                    input last_of_run, output ready);
endinterface

/* design/mke_front.sv */
// Front end: accept characters, fold case, look up the pattern, drop unmapped codes.
module mke_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mke_char_if.sink        i_char,
    input  logic            i_q_ready,
    output logic            o_q_push,
    output mke_pkg::t_desc  o_q_desc
);

    logic                       r_valid;
    mke_pkg::t_desc             r_desc;
    logic                       n_valid;
    mke_pkg::t_desc             n_desc;
    logic [mke_pkg::CHAR_W-1:0] folded;
    mke_pkg::t_pat              pat;
    logic                       is_space;
    logic                       accept;

    assign i_char.ready = !r_valid || i_q_ready;
    assign accept       = i_char.valid && i_char.ready;
    assign o_q_push     = r_valid;
    assign o_q_desc     = r_desc;

    always_comb begin
        folded = i_char.char_code;
        if (i_char.char_code >= mke_pkg::CHAR_LOW_A &&
            i_char.char_code <= mke_pkg::CHAR_LOW_Z) begin
            folded = i_char.char_code - mke_pkg::CASE_FOLD;
        end
        pat      = mke_pkg::mke_pattern(folded);
        is_space = (folded == mke_pkg::CHAR_SPACE);

        n_valid = r_valid && !i_q_ready;
        n_desc  = r_desc;
        if (accept) begin
            n_valid      = pat.ok || is_space;
            n_desc.space = is_space;
            n_desc.len   = pat.len;
            // Left-align so the first element sits in the MSB
            n_desc.bits  = pat.bits << (3'(mke_pkg::PAT_W) - pat.len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_desc <= n_desc;
    end

endmodule

/* design/mke_queue.sv */
// Short queue between the front end and the segment sequencer.
module mke_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mke_pkg::t_desc i_data,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output mke_pkg::t_desc o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mke_pkg::t_desc   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* design/mke_back.sv */
// Segment sequencer: step through marks and gaps, scale units, hold the output register.
module mke_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [mke_pkg::UNIT_W-1:0] i_unit,
    input  logic                       i_q_valid,
    input  mke_pkg::t_desc             i_q_desc,
    output logic                       o_q_pop,
    mke_seg_if.source                  o_seg
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MARK = 4'b0010,
        ST_GAP  = 4'b0100,
        ST_TAIL = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        UNITS_1 = 2'd0,
        UNITS_2 = 2'd1,
        UNITS_3 = 2'd2,
        UNITS_7 = 2'd3
    } t_units;

    t_state                      r_state, n_state;
    logic [mke_pkg::PAT_W-1:0]   r_bits, n_bits;
    logic [mke_pkg::LEN_W-1:0]   r_left, n_left;
    logic                        r_space, n_space;
    logic                        r_ovalid;
    logic                        r_key_down;
    logic [mke_pkg::DUR_W-1:0]   r_duration;
    logic                        r_last;

    logic                        adv;
    logic                        emit;
    logic                        seg_down;
    logic                        seg_last;
    t_units                      seg_units;
    logic [mke_pkg::DUR_W-1:0]   unit_x;
    logic [mke_pkg::DUR_W-1:0]   seg_dur;

    assign o_seg.valid       = r_ovalid;
    assign o_seg.key_down    = r_key_down;
    assign o_seg.duration_ms = r_duration;
    assign o_seg.last_of_run = r_last;

    assign adv     = !r_ovalid || o_seg.ready;
    assign emit    = (r_state != ST_IDLE) && adv;
    assign o_q_pop = i_q_valid && ((r_state == ST_IDLE) || (r_state == ST_TAIL && adv));
    assign unit_x  = mke_pkg::DUR_W'(i_unit);

    always_comb begin
        seg_down  = 1'b0;
        seg_last  = 1'b0;
        seg_units = UNITS_1;
        unique case (r_state)
            ST_MARK: begin
                seg_down  = 1'b1;
                seg_units = r_bits[mke_pkg::PAT_W-1] ? UNITS_3 : UNITS_1;
            end
            ST_GAP: begin
                seg_units = UNITS_1;
            end
            ST_TAIL: begin
                seg_last  = 1'b1;
                seg_units = r_space ? UNITS_7 : UNITS_2;
            end
            default: begin
                seg_units = UNITS_1;
            end
        endcase

        // Small constant multiples: at most one shift and one add or subtract
        unique case (seg_units)
            UNITS_1: seg_dur = unit_x;
            UNITS_2: seg_dur = unit_x << 1;
            UNITS_3: seg_dur = unit_x + (unit_x << 1);
            UNITS_7: seg_dur = (unit_x << 3) - unit_x;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_bits  = r_bits;
        n_left  = r_left;
        n_space = r_space;
        unique case (r_state)
            ST_MARK: begin
                if (adv) begin
                    n_state = ST_GAP;
                    n_bits  = r_bits << 1;
                    n_left  = r_left - 1'b1;
                end
            end
            ST_GAP: begin
                if (adv) begin
                    n_state = (r_left == '0) ? ST_TAIL : ST_MARK;
                end
            end
            ST_TAIL: begin
                if (adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
        // Load the next character as the current one finishes
        if (o_q_pop) begin
            n_space = i_q_desc.space;
            n_bits  = i_q_desc.bits;
            n_left  = i_q_desc.len;
            n_state = i_q_desc.space ? ST_TAIL : ST_MARK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_seg.ready) begin
                r_ovalid <= 1'b0;
            end
        end
        r_bits  <= n_bits;
        r_left  <= n_left;
        r_space <= n_space;
        if (emit) begin
            r_key_down <= seg_down;
            r_duration <= seg_dur;
            r_last     <= seg_last;
        end
    end

endmodule

/* design/morse_keying_encoder_unit.sv */
// Top level of the Morse keying encoder: APB register, front end, queue and sequencer.
// Path: front-end register, queue, sequencer state, output register.
// A character of n elements (at most 6) makes 2n+1 segments, a space one, a dropped code
// none. The sequencer sets the pace: one segment per cycle unless the output stalls.
// Front end and queue take characters while the sequencer works or stalls, until both fill.
// Reset is synchronous, active low: queue and sequencer empty, unit length back to 60 ms.
module morse_keying_encoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mke_char_if.sink                   i_char,
    mke_seg_if.source                  o_seg,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mke_pkg::ADDR_W-1:0] paddr,
    input  logic [mke_pkg::DATA_W-1:0] pwdata,
    output logic [mke_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    // Unit length register; software writes it only while the encoder is idle (the user
    // is bound, the block does not enforce it), so the sequencer reads it with no shadow copy.
    logic [mke_pkg::UNIT_W-1:0] r_unit;
    mke_pkg::t_reg_idx          reg_idx;
    logic                       cfg_wr;

    // Front end to queue, queue to sequencer
    logic                       fq_push;
    mke_pkg::t_desc             fq_desc;
    logic                       fq_ready;
    logic                       qb_valid;
    mke_pkg::t_desc             qb_desc;
    logic                       qb_pop;

    // Word address selects the register; the low two bits are the byte offset
    assign reg_idx = mke_pkg::t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            mke_pkg::REG_UNIT_LENGTH: prdata = mke_pkg::DATA_W'(r_unit);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= mke_pkg::UNIT_RESET;
        end else if (cfg_wr && reg_idx == mke_pkg::REG_UNIT_LENGTH) begin
            r_unit <= pwdata[mke_pkg::UNIT_W-1:0];
        end
    end

    // Classify each transaction; unmapped codes never reach the queue
    mke_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (i_char),
        .i_q_ready (fq_ready),
        .o_q_push  (fq_push),
        .o_q_desc  (fq_desc)
    );

    // Decouple: front end may run ahead by the queue depth plus its own register while output stalls
    mke_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  (fq_desc),
        .o_ready (fq_ready),
        .i_pop   (qb_pop),
        .o_valid (qb_valid),
        .o_data  (qb_desc)
    );

    // Emit mark, gap, ..., tail; the tail of one character overlaps the pop of the next
    mke_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_unit    (r_unit),
        .i_q_valid (qb_valid),
        .i_q_desc  (qb_desc),
        .o_q_pop   (qb_pop),
        .o_seg     (o_seg)
    );

endmodule

/* design/mke_checker.sv */
// Port-level checks of the keying encoder and the bind that attaches them.
module mke_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_key_down,
    input logic [mke_pkg::DUR_W-1:0]  i_duration_ms,
    input logic                       i_last_of_run,
    input logic [mke_pkg::DATA_W-1:0] i_prdata
);

    // A stalled segment holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_key_down) && $stable(i_duration_ms) && $stable(i_last_of_run))
        else $error("segment payload changed while stalled");

    // Every run ends in key-up, so a keyed segment never closes a run
    a_mark_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_key_down |-> !i_last_of_run)
        else $error("key-down segment marked as last of run");

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Read data carries only the 16-bit unit length
    a_prdata_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_prdata[mke_pkg::DATA_W-1:mke_pkg::UNIT_W] == '0)
        else $error("upper read data bits not zero");

endmodule

bind morse_keying_encoder_unit mke_checker u_mke_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_seg.valid),
    .i_out_ready   (o_seg.ready),
    .i_key_down    (o_seg.key_down),
    .i_duration_ms (o_seg.duration_ms),
    .i_last_of_run (o_seg.last_of_run),
    .i_prdata      (prdata)
);

/* tb/tb_morse_keying_encoder_unit.sv */
// Self-checking testbench of the Morse keying encoder: random stimulus, scoreboard, APB set-up.
`timescale 1ns / 100ps

module tb_morse_keying_encoder_unit;

    // Unit counts of the Morse timing rules
    localparam int DOT_UNITS         = 1;
    localparam int DASH_UNITS        = 3;
    localparam int ELEMENT_GAP_UNITS = 1;
    localparam int CHAR_GAP_UNITS    = 2;
    localparam int WORD_GAP_UNITS    = 7;

    // Cycles to let pass once the last segment is in: covers a dropped code still in flight
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 28;
    localparam int PHASES       = 7;

    typedef struct {
        logic                      key_down;
        logic [mke_pkg::DUR_W-1:0] duration_ms;
        logic                      last_of_run;
    } t_key_segment;

    // Scoreboard: predicts the key segments of each accepted character and checks the
    // segments that leave the block against them, oldest first.
    class morse_segment_checker;
        logic [mke_pkg::UNIT_W-1:0] unit_ms;
        t_key_segment               pending_segments[$];
        int unsigned                errors;

        function new();
            unit_ms = mke_pkg::UNIT_RESET;
            errors  = 0;
        endfunction

        // Dots and dashes of a folded character; empty where it has no Morse form
        function string morse_elements(logic [mke_pkg::CHAR_W-1:0] c);
            unique case (c)
                "A": return ".-";     "B": return "-...";   "C": return "-.-.";
                "D": return "-..";    "E": return ".";      "F": return "..-.";
                "G": return "--.";    "H": return "....";   "I": return "..";
                "J": return ".---";   "K": return "-.-";    "L": return ".-..";
                "M": return "--";     "N": return "-.";     "O": return "---";
                "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
                "S": return "...";    "T": return "-";      "U": return "..-";
                "V": return "...-";   "W": return ".--";    "X": return "-..-";
                "Y": return "-.--";   "Z": return "--..";
                "0": return "-----";  "1": return ".----";  "2": return "..---";
                "3": return "...--";  "4": return "....-";  "5": return ".....";
                "6": return "-....";  "7": return "--...";  "8": return "---..";
                "9": return "----.";
                "/": return "-..-.";  "?": return "..--..";
                ".": return ".-.-.-"; ",": return "--..--";
                default: return "";
            endcase
        endfunction

        function void push_segment(logic down, int unsigned units, logic last);
            t_key_segment s;
            s.key_down    = down;
            s.duration_ms = mke_pkg::DUR_W'(units * unit_ms);
            s.last_of_run = last;
            pending_segments.push_back(s);
        endfunction

        function void take_char(logic [mke_pkg::CHAR_W-1:0] code);
            logic [mke_pkg::CHAR_W-1:0] c;
            string                      els;
            c = code;
            if (c >= "a" && c <= "z") begin
                c = c - mke_pkg::CASE_FOLD;
            end
            if (c == mke_pkg::CHAR_SPACE) begin
                push_segment(1'b0, WORD_GAP_UNITS, 1'b1);
                return;
            end
            els = morse_elements(c);
            for (int i = 0; i < els.len(); i++) begin
                push_segment(1'b1, (els[i] == "-") ? DASH_UNITS : DOT_UNITS, 1'b0);
                push_segment(1'b0, ELEMENT_GAP_UNITS, 1'b0);
            end
            if (els.len() > 0) begin
                push_segment(1'b0, CHAR_GAP_UNITS, 1'b1);
            end
        endfunction

        function void check_segment(logic kd, logic [mke_pkg::DUR_W-1:0] dur, logic last);
            t_key_segment s;
            if (pending_segments.size() == 0) begin
                $display("%0t: unexpected segment, expected none, %s%0d %s%0d %s%0d",
                         $time, "actual key_down=", kd, "duration=", dur, "last=", last);
                errors++;
                return;
            end
            s = pending_segments.pop_front();
            if (kd !== s.key_down || dur !== s.duration_ms || last !== s.last_of_run) begin
                $display("%0t: segment mismatch, expected key_down=%0d duration=%0d last=%0d,",
                         $time, s.key_down, s.duration_ms, s.last_of_run);
                $display("%0t:   actual key_down=%0d duration=%0d last=%0d",
                         $time, kd, dur, last);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_segments.size();
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [mke_pkg::ADDR_W-1:0]  paddr;
    logic [mke_pkg::DATA_W-1:0]  pwdata;
    logic [mke_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    mke_char_if char_ch();
    mke_seg_if  seg_ch();

    // Idling switches, set per phase by the stimulus process
    bit in_gaps;
    bit out_gaps;

    morse_segment_checker book = new();

    // Directed characters: letters both cases, digits, every mark, space, and unmapped
    // codes at both ends of the code range and next to each letter range
    logic [mke_pkg::CHAR_W-1:0] directed_chars[23] = '{
        "A", "z", "E", "T", "Q", "0", "9", "5", "/", "?", ".", ",", " ",
        8'h00, 8'hFF, 8'h80, 8'h7F, "@", "[", 8'h60, "{", "a", "Z"
    };

    morse_keying_encoder_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .o_seg   (seg_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hold the run to a fixed ceiling; a hung handshake ends here
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Segment sink: drop ready at random while stalls are enabled
    initial begin
        seg_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (out_gaps && $urandom_range(0, 5) == 0) begin
                seg_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            seg_ch.ready <= 1'b1;
        end
    end

    // Monitor: note each accepted character, check each accepted segment.
    // Sample before the edge's updates land, so both sides see the handshake values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (char_ch.valid && char_ch.ready) begin
                book.take_char(char_ch.char_code);
            end
            if (seg_ch.valid && seg_ch.ready) begin
                book.check_segment(seg_ch.key_down, seg_ch.duration_ms, seg_ch.last_of_run);
            end
        end
    end

    // Present one character and hold it until the block takes it; the caller's next
    // call or the drain decides what valid does after the accepting edge.
    task automatic send_char(logic [mke_pkg::CHAR_W-1:0] code);
        if (in_gaps && $urandom_range(0, 3) == 0) begin
            char_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= code;
        do @(posedge i_clk); while (!char_ch.ready);
    endtask

    // Drop valid, wait for every predicted segment, then give a dropped code time to clear
    task automatic settle_encoder();
        char_ch.valid <= 1'b0;
        do @(posedge i_clk); while (book.outstanding() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_register(mke_pkg::t_reg_idx idx, logic [mke_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mke_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == mke_pkg::REG_UNIT_LENGTH) begin
            book.unit_ms = value[mke_pkg::UNIT_W-1:0];
        end
    endtask

    // Mostly well-formed text, with a tenth of the codes drawn from the whole byte range
    function automatic logic [mke_pkg::CHAR_W-1:0] random_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return mke_pkg::CHAR_W'($urandom_range(8'h41, 8'h5A));
        if (roll < 60) begin
            return mke_pkg::CHAR_W'($urandom_range(mke_pkg::CHAR_LOW_A, mke_pkg::CHAR_LOW_Z));
        end
        if (roll < 75) return mke_pkg::CHAR_W'($urandom_range(8'h30, 8'h39));
        if (roll < 83) begin
            unique case ($urandom_range(0, 3))
                0: return "/";
                1: return "?";
                2: return ".";
                default: return ",";
            endcase
        end
        if (roll < 90) return mke_pkg::CHAR_SPACE;
        return mke_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [mke_pkg::UNIT_W-1:0] unit_value;

        i_rst_n           <= 1'b0;
        char_ch.valid     <= 1'b0;
        char_ch.char_code <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_gaps            = 1'b1;
        out_gaps           = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset unit length
        foreach (directed_chars[i]) begin
            send_char(directed_chars[i]);
        end

        // Random phases, each under its own unit length: reset value, shortest, longest, zero,
        // random values, then a final stretch at 60 with no idling on either side
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                settle_encoder();
                case (ph)
                    1: unit_value = 16'd1;
                    2: unit_value = 16'hFFFF;
                    3: unit_value = 16'd0;
                    6: unit_value = 16'd60;
                    default: unit_value = mke_pkg::UNIT_W'($urandom_range(1, 65535));
                endcase
                write_register(mke_pkg::REG_UNIT_LENGTH, mke_pkg::DATA_W'(unit_value));
            end
            if (ph == PHASES - 1) begin
                in_gaps  = 1'b0;
                out_gaps = 1'b0;
            end else begin
                in_gaps  = ($urandom_range(0, 2) != 0);
                out_gaps = ($urandom_range(0, 2) != 0);
            end
            repeat (PHASE_ITEMS) send_char(random_char());
        end

        settle_encoder();
        if (book.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* morse_keying_encoder_unit.f */
design/mke_pkg.sv
design/mke_if.sv
design/mke_front.sv
design/mke_queue.sv
design/mke_back.sv
design/morse_keying_encoder_unit.sv
design/mke_checker.sv
tb/tb_morse_keying_encoder_unit.sv
